// ----- rtl/core/yuv2rgb_pkg.sv -----
package yuv2rgb_pkg;

  // Register stages inside one conversion lane, and the whole pipeline
  // including the output register of the merge stage.
  localparam int unsigned LaneStages = 8;
  localparam int unsigned PipeStages = LaneStages + 1;

  // BT.601 coefficients at scale 10000.
  localparam logic [21:0] CoefLuma    = 22'd11644;
  localparam logic [21:0] CoefRedCr   = 22'd15938;
  localparam logic [22:0] CoefBlueCb  = 23'd20238;
  localparam logic [22:0] CoefGreenY  = 23'd19837;
  localparam logic [20:0] CoefGreenR  = 21'd5094;
  localparam logic [18:0] CoefGreenB  = 19'd1942;

  localparam logic signed [23:0] RedOffset   = 24'sd2221300;
  localparam logic signed [23:0] BlueOffset  = 24'sd2771300;
  localparam logic signed [23:0] GreenOffset = 24'sd311710;

  // Division by 10000 as a multiply by ceil(2^36 / 10000) and a shift by 36.
  // Exact for every numerator below the clamp threshold.
  localparam logic [22:0]        DivRecip   = 23'd6871948;
  localparam int unsigned        DivShift   = 36;
  localparam logic signed [23:0] ClampHigh  = 24'sd2560000;

  localparam logic [15:0] MaskRed565   = 16'hF800;
  localparam logic [15:0] MaskGreen565 = 16'h07E0;

  typedef enum logic [1:0] {
    ORDER_YUYV = 2'd0,
    ORDER_YVYU = 2'd1,
    ORDER_UYVY = 2'd2,
    ORDER_VYUY = 2'd3
  } order_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

endpackage

// ----- rtl/core/yuv2rgb_lane.sv -----
module yuv2rgb_lane (
  input  logic                                  clk_i,
  input  logic [yuv2rgb_pkg::LaneStages-1:0]    en_i,
  input  logic [7:0]                            luma_i,
  input  logic [7:0]                            cb_i,
  input  logic [7:0]                            cr_i,
  output yuv2rgb_pkg::pixel_t                   pixel_o
);
  import yuv2rgb_pkg::*;

  // Multiply by the reciprocal of 10000; only valid below the clamp threshold.
  function automatic logic [7:0] div_quot(logic signed [23:0] num);
    logic [44:0] prod;
    prod = 45'(num[21:0]) * 45'(DivRecip);
    return prod[DivShift+7:DivShift];
  endfunction

  // Stage 1: constant products.
  logic [21:0] yl_q, crp_q;
  logic [22:0] cbp_q, y2_q;
  // Stage 2: red and blue numerators.
  logic signed [23:0] rnum_q, bnum_q;
  logic [22:0] y2_s2_q;
  // Stage 3: quotients and clamp flags.
  logic [7:0] rquo_q, bquo_q;
  logic r_neg_q, r_hi_q, b_neg_q, b_hi_q;
  logic [22:0] y2_s3_q;
  // Stage 4: clamped red and blue.
  logic [7:0] r_s4_q, b_s4_q;
  logic [22:0] y2_s4_q;
  // Stage 5: green correction products.
  logic [20:0] pr_q;
  logic [18:0] pb_q;
  logic [7:0] r_s5_q, b_s5_q;
  logic [22:0] y2_s5_q;
  // Stage 6: green numerator.
  logic signed [23:0] gnum_q;
  logic [7:0] r_s6_q, b_s6_q;
  // Stage 7: green quotient and flags.
  logic [7:0] gquo_q;
  logic g_neg_q, g_hi_q;
  logic [7:0] r_s7_q, b_s7_q;
  // Stage 8: result.
  pixel_t pix_q;

  logic signed [23:0] rnum_d, bnum_d, gnum_d;

  always_comb begin
    rnum_d = $signed({2'b00, crp_q}) + $signed({2'b00, yl_q}) - RedOffset;
    bnum_d = $signed({1'b0, cbp_q}) + $signed({2'b00, yl_q}) - BlueOffset;
    gnum_d = $signed({1'b0, y2_s5_q}) - GreenOffset - $signed({3'b000, pr_q})
             - $signed({5'b00000, pb_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      yl_q  <= 22'({14'd0, luma_i} * CoefLuma);
      crp_q <= 22'({14'd0, cr_i} * CoefRedCr);
      cbp_q <= 23'({15'd0, cb_i} * CoefBlueCb);
      y2_q  <= 23'({15'd0, luma_i} * CoefGreenY);
    end
    if (en_i[1]) begin
      rnum_q  <= rnum_d;
      bnum_q  <= bnum_d;
      y2_s2_q <= y2_q;
    end
    if (en_i[2]) begin
      rquo_q  <= div_quot(rnum_q);
      bquo_q  <= div_quot(bnum_q);
      r_neg_q <= rnum_q[23];
      r_hi_q  <= !rnum_q[23] && (rnum_q >= ClampHigh);
      b_neg_q <= bnum_q[23];
      b_hi_q  <= !bnum_q[23] && (bnum_q >= ClampHigh);
      y2_s3_q <= y2_s2_q;
    end
    if (en_i[3]) begin
      r_s4_q  <= r_neg_q ? 8'd0 : (r_hi_q ? 8'd255 : rquo_q);
      b_s4_q  <= b_neg_q ? 8'd0 : (b_hi_q ? 8'd255 : bquo_q);
      y2_s4_q <= y2_s3_q;
    end
    if (en_i[4]) begin
      pr_q    <= 21'({13'd0, r_s4_q} * CoefGreenR);
      pb_q    <= 19'({11'd0, b_s4_q} * CoefGreenB);
      r_s5_q  <= r_s4_q;
      b_s5_q  <= b_s4_q;
      y2_s5_q <= y2_s4_q;
    end
    if (en_i[5]) begin
      gnum_q <= gnum_d;
      r_s6_q <= r_s5_q;
      b_s6_q <= b_s5_q;
    end
    if (en_i[6]) begin
      gquo_q  <= div_quot(gnum_q);
      g_neg_q <= gnum_q[23];
      g_hi_q  <= !gnum_q[23] && (gnum_q >= ClampHigh);
      r_s7_q  <= r_s6_q;
      b_s7_q  <= b_s6_q;
    end
    if (en_i[7]) begin
      pix_q.red   <= r_s7_q;
      pix_q.green <= g_neg_q ? 8'd0 : (g_hi_q ? 8'd255 : gquo_q);
      pix_q.blue  <= b_s7_q;
    end
  end

  assign pixel_o = pix_q;

endmodule

// ----- rtl/core/yuv2rgb_merge.sv -----
module yuv2rgb_merge (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  yuv2rgb_pkg::pixel_t  first_i,
  input  yuv2rgb_pkg::pixel_t  second_i,
  input  logic                 frame_end_i,
  output yuv2rgb_pkg::pixel_t  first_o,
  output yuv2rgb_pkg::pixel_t  second_o,
  output logic [15:0]          first_rgb565_o,
  output logic [15:0]          second_rgb565_o,
  output logic                 frame_end_o
);
  import yuv2rgb_pkg::*;

  function automatic logic [15:0] pack565(pixel_t p);
    return (({8'd0, p.red} << 8) & MaskRed565) | (({8'd0, p.green} << 3) & MaskGreen565)
           | {11'd0, p.blue[7:3]};
  endfunction

  pixel_t      first_q, second_q;
  logic [15:0] first565_q, second565_q;
  logic        frame_end_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      first_q     <= first_i;
      second_q    <= second_i;
      first565_q  <= pack565(first_i);
      second565_q <= pack565(second_i);
      frame_end_q <= frame_end_i;
    end
  end

  assign first_o         = first_q;
  assign second_o        = second_q;
  assign first_rgb565_o  = first565_q;
  assign second_rgb565_o = second565_q;
  assign frame_end_o     = frame_end_q;

endmodule

// ----- rtl/core/yuv422_packed_to_rgb_top.sv -----
// Packed YUV 4:2:2 to RGB888 and RGB565 converter, two luma lanes sharing chroma.
// An input beat passes through the lane stages and then the merge output register.
// Throughput: one macropixel per cycle while the output is not stalled; every pipeline
// stage holds its beat only while the stage after it is full and stalled, the last one while the output is.
// Reset clears all stage valid flags and sets the byte order to YUYV.
module yuv422_packed_to_rgb_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte0_i,
  input  logic [7:0]  byte1_i,
  input  logic [7:0]  byte2_i,
  input  logic [7:0]  byte3_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  first_red_o,
  output logic [7:0]  first_green_o,
  output logic [7:0]  first_blue_o,
  output logic [7:0]  second_red_o,
  output logic [7:0]  second_green_o,
  output logic [7:0]  second_blue_o,
  output logic [15:0] first_rgb565_o,
  output logic [15:0] second_rgb565_o,
  output logic        frame_end_out_o
);
  import yuv2rgb_pkg::*;

  order_e                 pixel_order_q;
  logic [PipeStages-1:0]  vld_q;
  logic [PipeStages-1:0]  rdy;
  logic [LaneStages-1:0]  fe_q;
  logic [7:0]             luma_a, luma_b, cb, cr;
  pixel_t                 lane_a, lane_b, first_px, second_px;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_order_q <= ORDER_YUYV;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pixel_order_q <= order_e'(cfg_data_i);
    end
  end

  always_comb begin
    unique case (pixel_order_q)
      ORDER_YUYV: begin
        luma_a = byte0_i; cb = byte1_i; luma_b = byte2_i; cr = byte3_i;
      end
      ORDER_YVYU: begin
        luma_a = byte0_i; cr = byte1_i; luma_b = byte2_i; cb = byte3_i;
      end
      ORDER_UYVY: begin
        cb = byte0_i; luma_a = byte1_i; cr = byte2_i; luma_b = byte3_i;
      end
      default: begin
        cr = byte0_i; luma_a = byte1_i; cb = byte2_i; luma_b = byte3_i;
      end
    endcase
  end

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    rdy[PipeStages-1] = !vld_q[PipeStages-1] || out_ready_i;
    for (int k = PipeStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[PipeStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < PipeStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      fe_q[0] <= frame_end_i;
    end
    for (int k = 1; k < LaneStages; k++) begin
      if (rdy[k]) begin
        fe_q[k] <= fe_q[k-1];
      end
    end
  end

  yuv2rgb_lane u_lane_first (
    .clk_i   (clk_i),
    .en_i    (rdy[LaneStages-1:0]),
    .luma_i  (luma_a),
    .cb_i    (cb),
    .cr_i    (cr),
    .pixel_o (lane_a)
  );

  yuv2rgb_lane u_lane_second (
    .clk_i   (clk_i),
    .en_i    (rdy[LaneStages-1:0]),
    .luma_i  (luma_b),
    .cb_i    (cb),
    .cr_i    (cr),
    .pixel_o (lane_b)
  );

  yuv2rgb_merge u_merge (
    .clk_i           (clk_i),
    .en_i            (rdy[PipeStages-1]),
    .first_i         (lane_a),
    .second_i        (lane_b),
    .frame_end_i     (fe_q[LaneStages-1]),
    .first_o         (first_px),
    .second_o        (second_px),
    .first_rgb565_o  (first_rgb565_o),
    .second_rgb565_o (second_rgb565_o),
    .frame_end_o     (frame_end_out_o)
  );

  assign first_red_o    = first_px.red;
  assign first_green_o  = first_px.green;
  assign first_blue_o   = first_px.blue;
  assign second_red_o   = second_px.red;
  assign second_green_o = second_px.green;
  assign second_blue_o  = second_px.blue;

endmodule

// ----- rtl/core/yuv2rgb_checker.sv -----
module yuv2rgb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  first_red_o,
  input logic [7:0]  first_green_o,
  input logic [7:0]  first_blue_o,
  input logic [7:0]  second_red_o,
  input logic [7:0]  second_green_o,
  input logic [7:0]  second_blue_o,
  input logic [15:0] first_rgb565_o,
  input logic [15:0] second_rgb565_o,
  input logic        frame_end_out_o
);

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_rgb565_o)
      && $stable(second_rgb565_o) && $stable(first_green_o)
      && $stable(second_green_o) && $stable(frame_end_out_o))
    else $error("output beat changed while stalled");

  // The packed words agree with the 8-bit components of the same beat.
  a_first_565: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> first_rgb565_o[15:11] == first_red_o[7:3]
      && first_rgb565_o[10:5] == first_green_o[7:2]
      && first_rgb565_o[4:0] == first_blue_o[7:3])
    else $error("first RGB565 word does not match first pixel");

  a_second_565: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> second_rgb565_o[15:11] == second_red_o[7:3]
      && second_rgb565_o[10:5] == second_green_o[7:2]
      && second_rgb565_o[4:0] == second_blue_o[7:3])
    else $error("second RGB565 word does not match second pixel");

  // The input side only stalls when the pipeline is full and the output is stalled.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the output can drain");

endmodule

bind yuv422_packed_to_rgb_top yuv2rgb_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .first_red_o     (first_red_o),
  .first_green_o   (first_green_o),
  .first_blue_o    (first_blue_o),
  .second_red_o    (second_red_o),
  .second_green_o  (second_green_o),
  .second_blue_o   (second_blue_o),
  .first_rgb565_o  (first_rgb565_o),
  .second_rgb565_o (second_rgb565_o),
  .frame_end_out_o (frame_end_out_o)
);

// ----- tb/yuv_rgb_checker.sv -----
module yuv_rgb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  byte0_i,
  input  logic [7:0]  byte1_i,
  input  logic [7:0]  byte2_i,
  input  logic [7:0]  byte3_i,
  input  logic        frame_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  first_red_i,
  input  logic [7:0]  first_green_i,
  input  logic [7:0]  first_blue_i,
  input  logic [7:0]  second_red_i,
  input  logic [7:0]  second_green_i,
  input  logic [7:0]  second_blue_i,
  input  logic [15:0] first_rgb565_i,
  input  logic [15:0] second_rgb565_i,
  input  logic        frame_end_out_i,
  output int          mismatches_o,
  output int          pending_o
);
  import yuv2rgb_pkg::*;

  localparam int Scale = 10000;

  typedef struct packed {
    pixel_t      first;
    pixel_t      second;
    logic [15:0] first565;
    logic [15:0] second565;
    logic        frame_end;
  } rgb_pair_t;

  order_e    pixel_order;
  rgb_pair_t expected_pairs[$];
  rgb_pair_t oldest;
  int        mismatch_count = 0;

  function automatic logic [7:0] clamp_scaled(int num);
    int q;
    // Integer division truncates toward zero; every negative quotient becomes 0.
    q = num / Scale;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  function automatic pixel_t convert_sample(int luma, int cb, int cr);
    int     luma_term;
    pixel_t px;
    luma_term = 11644 * luma;
    px.red   = clamp_scaled(15938 * cr - 2221300 + luma_term);
    px.blue  = clamp_scaled(20238 * cb - 2771300 + luma_term);
    // Green is derived from the already clamped red and blue.
    px.green = clamp_scaled(19837 * luma - 311710
                            - 5094 * int'(px.red) - 1942 * int'(px.blue));
    return px;
  endfunction

  function automatic logic [15:0] pack565(pixel_t px);
    return {px.red[7:3], px.green[7:2], px.blue[7:3]};
  endfunction

  function automatic rgb_pair_t predict_pair(order_e order, logic [7:0] b0, logic [7:0] b1,
                                             logic [7:0] b2, logic [7:0] b3, logic fe);
    logic [7:0] ya, yb, cb, cr;
    rgb_pair_t  pair;
    case (order)
      ORDER_YUYV: begin ya = b0; cb = b1; yb = b2; cr = b3; end
      ORDER_YVYU: begin ya = b0; cr = b1; yb = b2; cb = b3; end
      ORDER_UYVY: begin cb = b0; ya = b1; cr = b2; yb = b3; end
      default:    begin cr = b0; ya = b1; cb = b2; yb = b3; end
    endcase
    pair.first     = convert_sample(int'(ya), int'(cb), int'(cr));
    pair.second    = convert_sample(int'(yb), int'(cb), int'(cr));
    pair.first565  = pack565(pair.first);
    pair.second565 = pack565(pair.second);
    pair.frame_end = fe;
    return pair;
  endfunction

  function automatic void check_field(string name, int expected_val, int actual_val);
    if (expected_val != actual_val) begin
      $error("%s: expected %0d, actual %0d", name, expected_val, actual_val);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_order  <= ORDER_YUYV;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      // Retire the output beat first; it can never belong to this edge's input beat.
      if (out_valid_i && out_ready_i) begin
        if (expected_pairs.size() == 0) begin
          $error("output beat with no expected result waiting");
          mismatch_count++;
        end else begin
          oldest = expected_pairs.pop_front();
          check_field("first_red", oldest.first.red, first_red_i);
          check_field("first_green", oldest.first.green, first_green_i);
          check_field("first_blue", oldest.first.blue, first_blue_i);
          check_field("second_red", oldest.second.red, second_red_i);
          check_field("second_green", oldest.second.green, second_green_i);
          check_field("second_blue", oldest.second.blue, second_blue_i);
          check_field("first_rgb565", oldest.first565, first_rgb565_i);
          check_field("second_rgb565", oldest.second565, second_rgb565_i);
          check_field("frame_end_out", oldest.frame_end, frame_end_out_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_pairs.push_back(predict_pair(pixel_order, byte0_i, byte1_i, byte2_i,
                                              byte3_i, frame_end_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        pixel_order <= order_e'(cfg_data_i);
      end
      pending_o    <= expected_pairs.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  import yuv2rgb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  byte0_i;
  logic [7:0]  byte1_i;
  logic [7:0]  byte2_i;
  logic [7:0]  byte3_i;
  logic        frame_end_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  first_red_o;
  logic [7:0]  first_green_o;
  logic [7:0]  first_blue_o;
  logic [7:0]  second_red_o;
  logic [7:0]  second_green_o;
  logic [7:0]  second_blue_o;
  logic [15:0] first_rgb565_o;
  logic [15:0] second_rgb565_o;
  logic        frame_end_out_o;

  int mismatches;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;

  order_e phase_order [8];

  yuv422_packed_to_rgb_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .byte0_i         (byte0_i),
    .byte1_i         (byte1_i),
    .byte2_i         (byte2_i),
    .byte3_i         (byte3_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .first_red_o     (first_red_o),
    .first_green_o   (first_green_o),
    .first_blue_o    (first_blue_o),
    .second_red_o    (second_red_o),
    .second_green_o  (second_green_o),
    .second_blue_o   (second_blue_o),
    .first_rgb565_o  (first_rgb565_o),
    .second_rgb565_o (second_rgb565_o),
    .frame_end_out_o (frame_end_out_o)
  );

  yuv_rgb_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .byte0_i         (byte0_i),
    .byte1_i         (byte1_i),
    .byte2_i         (byte2_i),
    .byte3_i         (byte3_i),
    .frame_end_i     (frame_end_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .first_red_i     (first_red_o),
    .first_green_i   (first_green_o),
    .first_blue_i    (first_blue_o),
    .second_red_i    (second_red_o),
    .second_green_i  (second_green_o),
    .second_blue_i   (second_blue_o),
    .first_rgb565_i  (first_rgb565_o),
    .second_rgb565_i (second_rgb565_o),
    .frame_end_out_i (frame_end_out_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  // Bias toward the levels where the clamps and the nominal video range sit.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd16;
      3: return 8'd235;
      4: return 8'd128;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_macropixel(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                 logic [7:0] b3, logic fe);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    byte0_i     <= b0;
    byte1_i     <= b1;
    byte2_i     <= b2;
    byte3_i     <= b3;
    frame_end_i <= fe;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Lets the pipeline drain completely so the byte order never changes under a beat.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (PipeStages + 2) @(posedge clk_i);
  endtask

  task automatic write_pixel_order(order_e order);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= order;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = ORDER_YUYV;
    in_valid_i  = 1'b0;
    byte0_i     = 8'd0;
    byte1_i     = 8'd0;
    byte2_i     = 8'd0;
    byte3_i     = 8'd0;
    frame_end_i = 1'b0;
    phase_order = '{ORDER_VYUY, ORDER_YVYU, ORDER_UYVY, ORDER_YUYV,
                    ORDER_VYUY, ORDER_UYVY, ORDER_YVYU, ORDER_YUYV};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats under the reset byte order YUYV: Y0, Cb, Y1, Cr.
    send_macropixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_macropixel(8'd0, 8'd128, 8'd255, 8'd128, 1'b0);
    send_macropixel(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
    send_macropixel(8'd255, 8'd0, 8'd255, 8'd255, 1'b0);
    send_macropixel(8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd255, 8'd0, 8'd0, 1'b1);
    send_macropixel(8'd128, 8'd0, 8'd128, 8'd0, 1'b0);
    send_macropixel(8'd0, 8'd255, 8'd255, 8'd255, 1'b0);
    send_macropixel(8'd81, 8'd90, 8'd145, 8'd240, 1'b0);
    send_macropixel(8'd41, 8'd240, 8'd210, 8'd16, 1'b0);
    send_macropixel(8'd235, 8'd16, 8'd16, 8'd240, 1'b0);
    send_macropixel(8'd16, 8'd240, 8'd235, 8'd16, 1'b0);
    send_macropixel(8'd1, 8'd127, 8'd254, 8'd129, 1'b0);
    send_macropixel(8'd170, 8'd85, 8'd85, 8'd170, 1'b0);
    send_macropixel(8'd85, 8'd170, 8'd170, 8'd85, 1'b0);
    send_macropixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b1);

    // Each phase pairs a byte order with one pattern of input idles and output stalls.
    for (int phase = 0; phase < 8; phase++) begin
      write_pixel_order(phase_order[phase]);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      for (int n = 0; n < 68; n++) begin
        send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                        ($urandom_range(15) == 0));
      end
    end

    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
